// ===== sv/tcw_pkg.sv =====
// Shared types and constants of the text console character writer.
package tcw_pkg;

	// Character codes that the console acts on.
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_PRINT_END = 8'h80;

	localparam logic [7:0] RESET_ATTR = 8'h0F;
	localparam int unsigned TAB_STOP  = 8;

	// Kind of work one beat asks for, decided by the front end.
	typedef enum logic [2:0] {
		OP_PRINT,
		OP_BACKSPACE,
		OP_TAB,
		OP_CR,
		OP_LF,
		OP_NOP,
		OP_READ,
		OP_READ_OOR
	} op_t;

	// One classified beat as it waits in the queue.
	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic [15:0] cell_value;
		logic [4:0]  row;
		logic [6:0]  col;
		logic        scrolled;
	} result_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_BLANK,
		BK_EMIT
	} back_state_t;

endpackage

// ===== sv/tcw_front.sv =====
// Front end: takes input beats and classifies them into console operations.
module tcw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [23:0]     s_tdata,
	input  logic            s_tuser,
	input  logic            q_full,
	output logic            push,
	output tcw_pkg::item_t  push_item
);
	import tcw_pkg::*;

	logic [7:0] ch;
	logic [4:0] rrow;
	logic [6:0] rcol;

	assign ch   = s_tdata[7:0];
	assign rrow = s_tdata[12:8];
	assign rcol = s_tdata[19:13];

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		push_item.ch  = ch;
		push_item.row = rrow;
		push_item.col = rcol;
		if (s_tuser) begin
			// A read outside the screen answers zero without touching the store.
			if (({1'b0, rrow} < 6'(ROWS)) && ({1'b0, rcol} < 8'(COLUMNS))) begin
				push_item.op = OP_READ;
			end else begin
				push_item.op = OP_READ_OOR;
			end
		end else if (ch == CH_BACKSPACE) begin
			push_item.op = OP_BACKSPACE;
		end else if (ch == CH_TAB) begin
			push_item.op = OP_TAB;
		end else if (ch == CH_CR) begin
			push_item.op = OP_CR;
		end else if (ch == CH_LF) begin
			push_item.op = OP_LF;
		end else if (ch >= CH_SPACE && ch < CH_PRINT_END) begin
			push_item.op = OP_PRINT;
		end else begin
			push_item.op = OP_NOP;
		end
	end

endmodule

// ===== sv/tcw_queue.sv =====
// Two-entry queue between the front end and the back end.
module tcw_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcw_pkg::item_t  push_item,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output tcw_pkg::item_t  pop_item
);
	import tcw_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== sv/tcw_back.sv =====
// Back end: cursor, screen store with rolling row base, scroll blanking and result register.
module tcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  logic             q_valid,
	input  tcw_pkg::item_t   q_item,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output tcw_pkg::result_t m_result
);
	import tcw_pkg::*;

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);

	back_state_t       state_q, state_d;
	logic [4:0]        row_q, row_d;
	logic [6:0]        col_q, col_d;
	logic [4:0]        base_q, base_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [ADDR_W-1:0] blank_addr_q, blank_addr_d;
	result_t           res_q, res_d;
	result_t           out_q, out_d;
	logic              out_vld_q, out_vld_d;
	logic [7:0]        text_color_q;

	logic [15:0]       mem [CELLS];
	logic [15:0]       rdata_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;

	logic [7:0]        col_x;
	logic [5:0]        row_x;
	logic              scroll;
	logic [4:0]        base_inc;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] rd_addr;

	// Logical row to physical row: the store is a ring of rows starting at base_q.
	function automatic logic [4:0] phys_row(input logic [4:0] r, input logic [4:0] b);
		logic [5:0] s;
		s = {1'b0, r} + {1'b0, b};
		if (s >= 6'(ROWS)) begin
			s = s - 6'(ROWS);
		end
		return s[4:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] pr, input logic [6:0] c);
		return ADDR_W'(pr) * ADDR_W'(COLUMNS) + ADDR_W'(c);
	endfunction

	assign cur_addr = cell_addr(phys_row(row_q, base_q), col_q);
	assign rd_addr  = cell_addr(phys_row(q_item.row, base_q), q_item.col);
	assign base_inc = (base_q == 5'(ROWS - 1)) ? 5'd0 : base_q + 5'd1;

	// Cursor movement for the operation at the head of the queue.
	always_comb begin
		col_x = {1'b0, col_q};
		row_x = {1'b0, row_q};
		case (q_item.op)
			OP_BACKSPACE: begin
				if (col_q != 7'd0) begin
					col_x = col_x - 8'd1;
				end
			end
			OP_TAB: begin
				col_x = (col_x + 8'(TAB_STOP)) & ~8'(TAB_STOP - 1);
			end
			OP_CR: begin
				col_x = 8'd0;
			end
			OP_LF: begin
				col_x = 8'd0;
				row_x = row_x + 6'd1;
			end
			OP_PRINT: begin
				col_x = col_x + 8'd1;
			end
			default: begin
			end
		endcase
		if (col_x >= 8'(COLUMNS)) begin
			col_x = 8'd0;
			row_x = row_x + 6'd1;
		end
		scroll = (row_x >= 6'(ROWS));
		if (scroll) begin
			row_x = 6'(ROWS - 1);
		end
	end

	always_comb begin
		state_d      = state_q;
		row_d        = row_q;
		col_d        = col_q;
		base_d       = base_q;
		cnt_d        = cnt_q;
		blank_addr_d = blank_addr_q;
		res_d        = res_q;
		out_d        = out_q;
		out_vld_d    = out_vld_q && !m_tready;
		mem_we       = 1'b0;
		mem_waddr    = cnt_q;
		mem_wdata    = {RESET_ATTR, CH_SPACE};
		mem_re       = 1'b0;
		mem_raddr    = rd_addr;
		pop          = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
				if (cnt_q == ADDR_W'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = BK_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			BK_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					case (q_item.op)
						OP_READ: begin
							mem_re  = 1'b1;
							res_d   = '{cell_value: 16'd0, row: row_q, col: col_q,
								scrolled: 1'b0};
							state_d = BK_READ;
						end
						OP_READ_OOR: begin
							res_d   = '{cell_value: 16'd0, row: row_q, col: col_q,
								scrolled: 1'b0};
							state_d = BK_EMIT;
						end
						default: begin
							if (q_item.op == OP_PRINT) begin
								mem_we    = 1'b1;
								mem_waddr = cur_addr;
								mem_wdata = {text_color_q, q_item.ch};
							end
							row_d = row_x[4:0];
							col_d = col_x[6:0];
							res_d = '{cell_value: 16'd0, row: row_x[4:0], col: col_x[6:0],
								scrolled: scroll};
							if (scroll) begin
								// The old top row becomes the new bottom row.
								base_d       = base_inc;
								blank_addr_d = cell_addr(base_q, 7'd0);
								cnt_d        = '0;
								state_d      = BK_BLANK;
							end else begin
								state_d = BK_EMIT;
							end
						end
					endcase
				end
			end
			BK_READ: begin
				res_d.cell_value = rdata_q;
				state_d          = BK_EMIT;
			end
			BK_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = blank_addr_q + cnt_q;
				mem_wdata = {text_color_q, CH_SPACE};
				if (cnt_q == ADDR_W'(COLUMNS - 1)) begin
					cnt_d   = '0;
					state_d = BK_EMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			BK_EMIT: begin
				if (!out_vld_q || m_tready) begin
					out_d     = res_q;
					out_vld_d = 1'b1;
					state_d   = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		blank_addr_q <= blank_addr_d;
		res_q        <= res_d;
		out_q        <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_CLEAR;
			row_q        <= 5'd0;
			col_q        <= 7'd0;
			base_q       <= 5'd0;
			cnt_q        <= '0;
			out_vld_q    <= 1'b0;
			text_color_q <= RESET_ATTR;
		end else begin
			state_q   <= state_d;
			row_q     <= row_d;
			col_q     <= col_d;
			base_q    <= base_d;
			cnt_q     <= cnt_d;
			out_vld_q <= out_vld_d;
			if (cfg_we) begin
				text_color_q <= cfg_wdata;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_result = out_q;

endmodule

// ===== sv/text_console_char_writer.sv =====
// Top level of the text console character writer.
//
// Input beats arrive on the s_ stream. s_tuser selects the work: 0 puts the
// byte in s_tdata[7:0] through the console logic, 1 reads the cell at row
// s_tdata[12:8], column s_tdata[19:13]. Every input beat gives exactly one
// output beat on the m_ stream, in order, carrying the cell read (zero for a
// put or a read off the screen), the cursor after the beat and a scroll flag.
// The attribute used for written characters is set with cfg_we / cfg_wdata.
//
// A front end classifies beats into a two-entry queue; the back end owns the
// screen store (one write and one registered read per cycle) and the cursor.
// A put or a read off the screen passes from the queue through BK_IDLE and
// BK_EMIT to the output register; a read on the screen also passes BK_READ.
// The back end takes no new beat until it has handed the last result to the
// output register. A scroll only moves the row base of the ring of rows and
// blanks the new bottom row in BK_BLANK, one cell a cycle.
// After reset the back end clears all ROWS*COLUMNS cells to a white-on-black
// space, one cell a cycle; input beats queue up (two at most) but are not
// processed until that ends. The result sits in an output register; while
// the receiver stalls, one more result waits in the back end and the queue
// keeps taking beats until it is full.
module text_console_char_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_byte[7:0], read_row[12:8], read_col[19:13], zeros
	input  logic        s_tuser,   // func: 0 put, 1 read
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cell_value[15:0], cursor_row[20:16], cursor_col[27:21],
	                               // scrolled[28], zeros
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata  // text_color
);
	import tcw_pkg::*;

	logic    q_full;
	logic    q_valid;
	logic    push;
	logic    pop;
	item_t   push_item;
	item_t   q_item;
	result_t result;

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_item(push_item)
	);

	tcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.pop_item (q_item)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_result (result)
	);

	// Pack the result fields, cell value in the lowest bits.
	assign m_tdata = {3'b000, result.scrolled, result.col, result.row, result.cell_value};

endmodule
